// ===== rtl/alist_pkg.sv =====
// shared constants, types and codes of the array list block
package alist_pkg;

	localparam int DEPTH      = 8;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// fixed port widths
	localparam int KIND_W  = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 3;
	localparam int STAT_W  = 3;
	localparam int ECNT_W  = 4;

	// width wide enough to compare an index port value against the count
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;
	typedef logic [KIND_W-1:0]            kind_t;
	typedef logic [STAT_W-1:0]            stat_t;
	typedef logic [1:0]                   act_t;

	// operation codes
	localparam kind_t K_INS_HEAD = 3'd0;
	localparam kind_t K_INS_MID  = 3'd1;
	localparam kind_t K_INS_TAIL = 3'd2;
	localparam kind_t K_DEL_HEAD = 3'd3;
	localparam kind_t K_DEL_TAIL = 3'd4;
	localparam kind_t K_DEL_IDX  = 3'd5;
	localparam kind_t K_FIND     = 3'd6;
	localparam kind_t K_CLEAR    = 3'd7;

	// result status codes
	localparam stat_t STAT_DONE     = 3'd0;
	localparam stat_t STAT_FULL     = 3'd1;
	localparam stat_t STAT_EMPTY    = 3'd2;
	localparam stat_t STAT_BADIDX   = 3'd3;
	localparam stat_t STAT_NOTFOUND = 3'd4;

	// datapath actions
	localparam act_t ACT_NONE = 2'd0;
	localparam act_t ACT_INS  = 2'd1;
	localparam act_t ACT_DEL  = 2'd2;
	localparam act_t ACT_CLR  = 2'd3;

	typedef struct packed {
		logic  load;
		act_t  act;
		idx_t  pos;
		stat_t status;
		idx_t  found;
	} alist_cmd_t;

	typedef struct packed {
		cnt_t count;
		logic hit;
		idx_t hit_pos;
	} alist_stat_t;

endpackage

// ===== rtl/alist_ctrl.sv =====
// controller: handshake state machine and operation decode
module alist_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  alist_pkg::kind_t     kind,
	input  logic [alist_pkg::POS_W-1:0] position_in,
	input  alist_pkg::alist_stat_t dp_stat,
	output alist_pkg::alist_cmd_t  cmd
);
	import alist_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_HOLD = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;
	logic full;
	logic empty;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;

	assign out_valid = (state_q == S_HOLD);
	assign in_stall  = out_valid && out_stall;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		unique case (state_q)
			S_IDLE: state_d = accept ? S_HOLD : S_IDLE;
			S_HOLD: state_d = (accept || out_stall) ? S_HOLD : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign full    = (dp_stat.count == CNT_W'(DEPTH));
	assign empty   = (dp_stat.count == '0);
	assign pos_ext = CMP_W'(position_in);
	assign cnt_ext = CMP_W'(dp_stat.count);

	always_comb begin
		cmd        = '0;
		cmd.load   = accept;
		cmd.act    = ACT_NONE;
		cmd.status = STAT_DONE;
		unique case (kind)
			K_INS_HEAD: begin
				if (full) cmd.status = STAT_FULL;
				else cmd.act = ACT_INS;
			end
			K_INS_MID: begin
				if (full) begin
					cmd.status = STAT_FULL;
				end else begin
					cmd.act = ACT_INS;
					cmd.pos = IDX_W'(dp_stat.count >> 1);
				end
			end
			K_INS_TAIL: begin
				if (full) begin
					cmd.status = STAT_FULL;
				end else begin
					cmd.act = ACT_INS;
					cmd.pos = IDX_W'(dp_stat.count);
				end
			end
			K_DEL_HEAD: begin
				if (empty) cmd.status = STAT_EMPTY;
				else cmd.act = ACT_DEL;
			end
			K_DEL_TAIL: begin
				if (empty) begin
					cmd.status = STAT_EMPTY;
				end else begin
					cmd.act = ACT_DEL;
					cmd.pos = IDX_W'(dp_stat.count - cnt_t'(1));
				end
			end
			K_DEL_IDX: begin
				if (empty) begin
					cmd.status = STAT_EMPTY;
				end else if (pos_ext >= cnt_ext) begin
					cmd.status = STAT_BADIDX;
				end else begin
					cmd.act = ACT_DEL;
					cmd.pos = IDX_W'(position_in);
				end
			end
			K_FIND: begin
				if (dp_stat.hit) cmd.found = dp_stat.hit_pos;
				else cmd.status = STAT_NOTFOUND;
			end
			K_CLEAR: begin
				cmd.act = ACT_CLR;
			end
			default: cmd.act = ACT_NONE;
		endcase
	end

endmodule

// ===== rtl/alist_dp.sv =====
// datapath: entry cells, count, parallel search and result registers
module alist_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  alist_pkg::alist_cmd_t         cmd,
	input  logic signed [alist_pkg::VALUE_W-1:0] value,
	output alist_pkg::alist_stat_t        dp_stat,
	output alist_pkg::stat_t              status,
	output logic [alist_pkg::POS_W-1:0]   found_position,
	output logic [alist_pkg::ECNT_W-1:0]  entry_count
);
	import alist_pkg::*;

	word_t entries_q [DEPTH];
	word_t entries_d [DEPTH];
	cnt_t  count_q;
	cnt_t  count_d;
	word_t word;
	logic [DEPTH-1:0] match;
	stat_t status_q;
	idx_t  found_q;
	cnt_t  ecount_q;

	// sign-extend or truncate the port word to the stored width
	assign word = word_t'(value);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (i < int'(count_q)) && (entries_q[i] == word);
		end
	end

	// first matching cell wins
	always_comb begin
		dp_stat.count   = count_q;
		dp_stat.hit     = |match;
		dp_stat.hit_pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) dp_stat.hit_pos = IDX_W'(i);
		end
	end

	// each cell keeps its value, takes the new word or a neighbor's
	always_comb begin
		int up;
		int dn;
		for (int i = 0; i < DEPTH; i++) begin
			up = (i == DEPTH - 1) ? i : i + 1;
			dn = (i == 0) ? 0 : i - 1;
			entries_d[i] = entries_q[i];
			if (i >= int'(cmd.pos)) begin
				if (cmd.act == ACT_INS) begin
					entries_d[i] = (i == int'(cmd.pos)) ? word : entries_q[dn];
				end else if (cmd.act == ACT_DEL) begin
					entries_d[i] = entries_q[up];
				end
			end
		end
	end

	always_comb begin
		unique case (cmd.act)
			ACT_INS: count_d = count_q + cnt_t'(1);
			ACT_DEL: count_d = count_q - cnt_t'(1);
			ACT_CLR: count_d = '0;
			default: count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < DEPTH; i++) begin
				entries_q[i] <= entries_d[i];
			end
			status_q <= cmd.status;
			found_q  <= cmd.found;
			ecount_q <= count_d;
		end
	end

	assign status         = status_q;
	assign found_position = POS_W'(found_q);
	assign entry_count    = ECNT_W'(ecount_q);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count past depth");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.status == STAT_FULL) |=> (count_q == CNT_W'(DEPTH)))
		else $error("rejected insert changed the count");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.act == ACT_CLR) |=> (count_q == '0 && entry_count == '0))
		else $error("clear left entries");

	a_find_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && cmd.act == ACT_NONE && cmd.status == STAT_DONE && dp_stat.hit)
		|=> (count_q == $past(count_q)))
		else $error("find changed the count");
`endif

endmodule

// ===== rtl/array_list_insert_delete_search.sv =====
// top level of the array list block: controller plus datapath
// Keeps an ordered list of up to DEPTH (8) signed words and a count. Each
// item carries an operation code in kind: insert at head, middle (count/2)
// or tail, delete at head, tail or position_in, find value, or clear. Every
// item yields exactly one result: status (done, full, empty, bad index, not
// found), found_position (first matching index on a successful find, else 0)
// and entry_count after the operation. All cells shift in parallel and the
// search compares every cell at once, so an item is finished in the cycle it
// is accepted and its result shows on the output register in the next cycle.
// The block takes one item per cycle: the single output register is the
// only storage between the two sides, so in_stall rises only while a result
// is held and out_stall is high. Entries hold no reset value; only cells
// below the count are ever read.
module array_list_insert_delete_search (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input item channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [alist_pkg::KIND_W-1:0]         kind,
	input  logic signed [alist_pkg::VALUE_W-1:0] value,
	input  logic [alist_pkg::POS_W-1:0]          position_in,
	// result item channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [alist_pkg::STAT_W-1:0]         status,
	output logic [alist_pkg::POS_W-1:0]          found_position,
	output logic [alist_pkg::ECNT_W-1:0]         entry_count
);
	import alist_pkg::*;

	// command from the controller, current count and search hit back
	alist_cmd_t  cmd;
	alist_stat_t dp_stat;

	// handshake and decode of the operation against the current count
	alist_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.position_in (position_in),
		.dp_stat     (dp_stat),
		.cmd         (cmd)
	);

	// cells, count, compare bank and result register
	alist_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.value          (value),
		.dp_stat        (dp_stat),
		.status         (status),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

endmodule
